>>> design/bin128_to_decimal_defines.svh
// Assertion macros shared by the binary to decimal converter
`ifndef BIN128_TO_DECIMAL_DEFINES_SVH
`define BIN128_TO_DECIMAL_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define B2D_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b2d check failed");
// Consequent must hold in the cycle after the antecedent
`define B2D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b2d check failed");
`else
`define B2D_ASSERT_NOW(label, clk, rst, ante, cons)
`define B2D_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/b2d_pkg.sv
// Package: shared constants and control types of the binary to decimal converter
`timescale 1ns / 1ps
package b2d_pkg;
  localparam int VALUE_BITS_DEF = 128;
  localparam int DIGITS_DEF     = 40;
  localparam int WORD_W         = 64;
  localparam int DIGIT_W        = 4;

  typedef struct packed {
    logic load;   // start an item: take the value, clear the accumulator
    logic dbl;    // one shift-and-double round
    logic shift;  // drop the top digit, move the rest up
  } b2d_cmd_t;

  typedef struct packed {
    logic round_done;  // the round being run is the final one
    logic top_zero;    // top digit is zero
    logic one_left;    // only one digit remains
  } b2d_stat_t;
endpackage

>>> design/b2d_in_if.sv
// Interface: input channel carrying one 128-bit value per item
`timescale 1ns / 1ps
interface b2d_in_if
  import b2d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value_high;
  logic [WORD_W-1:0] value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

>>> design/b2d_out_if.sv
// Interface: output channel carrying one decimal digit per item
`timescale 1ns / 1ps
interface b2d_out_if
  import b2d_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last;

  modport source (output valid, output digit, output last, input ready);
  modport sink   (input valid, input digit, input last, output ready);
endinterface

>>> design/b2d_datapath.sv
// Datapath: value shift register, BCD accumulator and the round and digit counters
`timescale 1ns / 1ps
module b2d_datapath
  import b2d_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int DIGITS     = DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  b2d_cmd_t           cmd,
  input  logic [WORD_W-1:0]  value_high,
  input  logic [WORD_W-1:0]  value_low,
  output b2d_stat_t          stat,
  output logic [DIGIT_W-1:0] top_digit
);
  localparam int RND_W = $clog2(VALUE_BITS);
  localparam int REM_W = $clog2(DIGITS + 1);
  localparam int ACC_W = DIGITS * DIGIT_W;

  logic [2*WORD_W-1:0] full_value;
  logic [VALUE_BITS-1:0] value;
  logic [ACC_W-1:0]      acc;
  logic [ACC_W-1:0]      acc_dbl;
  logic [DIGITS-1:0]     carry;
  logic [RND_W-1:0]      rnd;
  logic [REM_W-1:0]      rem;

  assign full_value = {value_high, value_low};

  // Digit carries depend only on the digit below, so all digits double at once
  always_comb begin
    logic [DIGIT_W:0] sum;
    carry[0] = value[VALUE_BITS-1];
    for (int j = 1; j < DIGITS; j++) begin
      carry[j] = (acc[(j-1)*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5));
    end
    for (int j = 0; j < DIGITS; j++) begin
      sum = {acc[j*DIGIT_W +: DIGIT_W], 1'b0} + (DIGIT_W+1)'(carry[j]);
      if (sum > (DIGIT_W+1)'(9)) begin
        acc_dbl[j*DIGIT_W +: DIGIT_W] = DIGIT_W'(sum - (DIGIT_W+1)'(10));
      end else begin
        acc_dbl[j*DIGIT_W +: DIGIT_W] = sum[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= full_value[VALUE_BITS-1:0];
      acc   <= '0;
    end else if (cmd.dbl) begin
      value <= {value[VALUE_BITS-2:0], 1'b0};
      acc   <= acc_dbl;
    end else if (cmd.shift) begin
      acc   <= {acc[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
      rem <= '0;
    end else if (cmd.load) begin
      rnd <= '0;
      rem <= REM_W'(DIGITS);
    end else begin
      if (cmd.dbl) begin
        rnd <= rnd + RND_W'(1);
      end
      if (cmd.shift) begin
        rem <= rem - REM_W'(1);
      end
    end
  end

  assign top_digit       = acc[ACC_W-1 -: DIGIT_W];
  assign stat.round_done = (rnd == RND_W'(VALUE_BITS - 1));
  assign stat.top_zero   = (top_digit == '0);
  assign stat.one_left   = (rem == REM_W'(1));
endmodule

>>> design/b2d_ctrl.sv
// Controller: sequences load, conversion rounds, zero skipping and digit output
`timescale 1ns / 1ps
`include "bin128_to_decimal_defines.svh"
module b2d_ctrl
  import b2d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_last,
  input  b2d_stat_t stat,
  output b2d_cmd_t  cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_acc;
  logic       out_acc;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign out_last  = stat.one_left;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dbl = 1'b1;
        if (stat.round_done) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.one_left) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (stat.one_left) begin
            state_next = ST_IDLE;
          end else begin
            cmd.shift = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `B2D_ASSERT_NEXT(a_load_starts_conv, clk, rst, in_acc, state == ST_CONV)
  `B2D_ASSERT_NEXT(a_conv_runs_all_rounds, clk, rst, (state == ST_CONV) && !stat.round_done, state == ST_CONV)
  `B2D_ASSERT_NEXT(a_last_digit_frees, clk, rst, out_acc && out_last, state == ST_IDLE)
  `B2D_ASSERT_NOW(a_no_skip_past_last, clk, rst, state == ST_SKIP, !(cmd.shift && stat.one_left))
endmodule

>>> design/bin128_to_decimal.sv
// Top level: 128-bit binary to decimal converter, one digit per output item
`timescale 1ns / 1ps
// Sequence: load, one shift-and-double round per converted value bit, then one skip step
//   per leading zero digit dropped, and a step into emitting before the first digit.
// Flow: a new value is taken only when idle, after the last digit of the one before;
//   one shared doubling stage, and the output shifts one digit per cycle while it is ready.
// Reset: synchronous, active high; clears the controller and counters, value and accumulator hold.
module bin128_to_decimal
  import b2d_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,  // low bits of the 128-bit input converted
  parameter int DIGITS     = DIGITS_DEF       // BCD accumulator digits
) (
  input logic       clk,
  input logic       rst,
  b2d_in_if.sink    in_item,
  b2d_out_if.source out_item
);
  // Command and status travel between controller and datapath only
  b2d_cmd_t           cmd;
  b2d_stat_t          stat;
  logic [DIGIT_W-1:0] top_digit;

  // Controller: idle, convert, skip leading zeros, emit digits
  b2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_last  (out_item.last),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: the top accumulator digit is the output item while emitting,
  // so a stalled output holds simply because no shift is issued
  b2d_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value_high (in_item.value_high),
    .value_low  (in_item.value_low),
    .stat       (stat),
    .top_digit  (top_digit)
  );

  assign out_item.digit = top_digit;
endmodule
